### hdl/mtrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtrc_pkg
// shared types and constants of the motor thermal estimator
// ----------------------------------------------------------------------------
package mtrc_pkg;

  localparam int unsigned COUNT_WIDTH = 10;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_AVG_STEPS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_INNER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_OUTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_COIL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_AIR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TEMP = 3'd7;

  localparam logic [COUNT_WIDTH-1:0] AVG_STEPS_RST = COUNT_WIDTH'(10);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [TIME_W-1:0]       now;
  } mtrc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mtrc_qstat_t;

endpackage
`default_nettype wire

### hdl/mtrc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtrc_front
// accumulates torque samples and posts one update job per window
// ----------------------------------------------------------------------------
module mtrc_front import mtrc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic signed [31:0]     torque_i,
  input  wire logic [TIME_W-1:0]      now_i,
  input  wire logic [COUNT_WIDTH-1:0] avg_steps_i,
  output logic                        push_o,
  output mtrc_job_t                   job_o
);

  logic signed [SUM_W-1:0] sum_q;
  logic [COUNT_WIDTH-1:0]  cnt_q;
  logic signed [SUM_W-1:0] sum_d;

  assign sum_d     = sum_q + SUM_W'(torque_i);
  assign push_o    = accept_i && (cnt_q <= COUNT_WIDTH'(1));
  assign job_o.sum = sum_d;
  assign job_o.now = now_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= AVG_STEPS_RST;
    end else if (accept_i) begin
      if (push_o) begin
        sum_q <= '0;
        cnt_q <= avg_steps_i;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_q - COUNT_WIDTH'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/mtrc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtrc_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module mtrc_queue import mtrc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire mtrc_job_t  job_i,
  input  wire logic       pop_i,
  output mtrc_job_t       job_o,
  output mtrc_qstat_t     stat_o
);

  mtrc_job_t  mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign job_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/mtrc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtrc_mul
// shared 64 x 48 multiplier, 16 bits of b per cycle
// ----------------------------------------------------------------------------
module mtrc_mul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [63:0]   a_i,
  input  wire logic [47:0]   b_i,
  output logic               done_o,
  output logic [111:0]       p_o
);

  logic [63:0]  a_q;
  logic [47:0]  b_q;
  logic [111:0] acc_q;
  logic [1:0]   cnt_q;
  logic         busy_q;
  logic         done_q;
  logic [79:0]  part;

  assign part   = a_q * b_q[47:32];
  assign done_o = done_q;
  assign p_o    = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[95:0], 16'd0} + 112'(part);
      b_q   <= {b_q[31:0], 16'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 2'd2);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/mtrc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtrc_back
// mean division, euler step of the three-node network, result register
// ----------------------------------------------------------------------------
module mtrc_back import mtrc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  output logic [COUNT_WIDTH-1:0]    avg_steps_o,
  input  wire mtrc_qstat_t          qstat_i,
  input  wire mtrc_job_t            job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [95:0]               out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MGO   = 3'd2;
  localparam logic [2:0] ST_MWAIT = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [3:0] OP_HEAT  = 4'd0;
  localparam logic [3:0] OP_FIN   = 4'd1;
  localparam logic [3:0] OP_FOUT  = 4'd2;
  localparam logic [3:0] OP_RCASE = 4'd3;
  localparam logic [3:0] OP_DCASE = 4'd4;
  localparam logic [3:0] OP_RCOIL = 4'd5;
  localparam logic [3:0] OP_DCOIL = 4'd6;
  localparam logic [3:0] OP_RAIR  = 4'd7;
  localparam logic [3:0] OP_DAIR  = 4'd8;

  logic [COUNT_WIDTH-1:0] avg_q;
  logic [31:0] inner_q, outer_q, icoil_q, icase_q, iair_q, gain_q;
  logic [31:0] coil_q, case_q, air_q;
  logic [TIME_W-1:0] last_q, dt_q;
  logic [2:0]  state_q;
  logic [3:0]  op_q;
  logic [3:0]  step_q;
  logic [SUM_W-1:0] dvd_q;
  logic [COUNT_WIDTH:0] rem_q;
  logic        neg_q;
  logic [31:0] mean_q, mmag_q;
  logic [55:0] heat_q, fin_q, fout_q;
  logic        fin_neg_q, fout_neg_q;
  logic [57:0] pcase_q, pcoil_q, pair_q;
  logic        pcase_neg_q, pcoil_neg_q, pair_neg_q;
  logic [63:0] rate_q;
  logic        out_valid_q;
  logic [95:0] out_q;

  logic [COUNT_WIDTH-1:0] divisor;
  logic [SUM_W-1:0]       dvd_d;
  logic [COUNT_WIDTH:0]   rem_d;
  logic [SUM_W-1:0]       sum_mag;
  logic                   mul_start, mul_done;
  logic [63:0]            mul_a;
  logic [47:0]            mul_b;
  logic [111:0]           prod;
  logic [63:0]            rate_new;
  logic [33:0]            delta;
  logic signed [58:0]     fin_s, fout_s, pc_s, pk_s, pa_s;

  function automatic logic [31:0] advance(logic [31:0] t, logic neg, logic [33:0] d);
    logic [34:0] s;
    s = 35'(t) + 35'(d);
    if (neg) begin
      advance = (d >= 34'(t)) ? 32'd0 : t - d[31:0];
    end else begin
      advance = (s[34:32] != 3'd0) ? 32'hffff_ffff : s[31:0];
    end
  endfunction

  function automatic logic [57:0] mag59(logic signed [58:0] v);
    logic [58:0] m;
    m = v[58] ? 59'(-v) : 59'(v);
    mag59 = m[57:0];
  endfunction

  assign avg_steps_o = avg_q;
  assign divisor     = (avg_q == '0) ? COUNT_WIDTH'(1) : avg_q;
  assign sum_mag     = job_i.sum[SUM_W-1] ? SUM_W'(-job_i.sum) : SUM_W'(job_i.sum);
  assign pop_o       = (state_q == ST_IDLE) && !qstat_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign mul_start   = (state_q == ST_MGO);

  // radix-16 restoring division step, divisor is narrow
  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int k = 0; k < 4; k++) begin
      rem_d = {rem_d[COUNT_WIDTH-1:0], dvd_d[SUM_W-1]};
      dvd_d = {dvd_d[SUM_W-2:0], 1'b0};
      if (rem_d >= {1'b0, divisor}) begin
        rem_d    = rem_d - {1'b0, divisor};
        dvd_d[0] = 1'b1;
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_q)
      OP_HEAT: begin
        mul_a = 64'(mmag_q);
        mul_b = 48'(gain_q);
      end
      OP_FIN: begin
        mul_a = 64'((coil_q >= case_q) ? coil_q - case_q : case_q - coil_q);
        mul_b = 48'(inner_q);
      end
      OP_FOUT: begin
        mul_a = 64'((air_q >= case_q) ? air_q - case_q : case_q - air_q);
        mul_b = 48'(outer_q);
      end
      OP_RCASE: begin
        mul_a = 64'(pcase_q);
        mul_b = 48'(icase_q);
      end
      OP_RCOIL: begin
        mul_a = 64'(pcoil_q);
        mul_b = 48'(icoil_q);
      end
      OP_RAIR: begin
        mul_a = 64'(pair_q);
        mul_b = 48'(iair_q);
      end
      OP_DCASE, OP_DCOIL, OP_DAIR: begin
        mul_a = rate_q;
        mul_b = dt_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rate_new = (prod[111:88] != '0) ? 64'hffff_ffff_ffff_ffff : prod[87:24];

  always_comb begin
    delta = (prod[111:70] != '0) ? 34'h2_0000_0000 : prod[69:36];
    if (delta > 34'h2_0000_0000) begin
      delta = 34'h2_0000_0000;
    end
  end

  assign fin_s  = fin_neg_q ? -59'(fin_q) : 59'(fin_q);
  assign fout_s = fout_neg_q ? -59'(fout_q) : 59'(fout_q);
  assign pc_s   = fout_s + fin_s;
  assign pk_s   = 59'(heat_q) - fin_s;
  assign pa_s   = -fout_s;

  mtrc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          dvd_q  <= sum_mag;
          rem_q  <= '0;
          neg_q  <= job_i.sum[SUM_W-1];
          dt_q   <= job_i.now - last_q;
          step_q <= 4'd0;
        end
      end
      ST_DIV: begin
        dvd_q  <= dvd_d;
        rem_q  <= rem_d;
        step_q <= step_q + 4'd1;
        if (step_q == 4'd11) begin
          if (neg_q) begin
            mmag_q <= (dvd_d > SUM_W'(32'h8000_0000)) ? 32'h8000_0000 : dvd_d[31:0];
            mean_q <= (dvd_d > SUM_W'(32'h8000_0000)) ? 32'h8000_0000 : -dvd_d[31:0];
          end else begin
            mmag_q <= (dvd_d > SUM_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : dvd_d[31:0];
            mean_q <= (dvd_d > SUM_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : dvd_d[31:0];
          end
        end
      end
      ST_MWAIT: begin
        if (mul_done) begin
          unique case (op_q)
            OP_HEAT: heat_q <= prod[63:8];
            OP_FIN: begin
              fin_q     <= prod[63:8];
              fin_neg_q <= coil_q < case_q;
            end
            OP_FOUT: begin
              fout_q     <= prod[63:8];
              fout_neg_q <= air_q < case_q;
            end
            OP_RCASE, OP_RCOIL, OP_RAIR: rate_q <= rate_new;
            default: ;
          endcase
        end
      end
      ST_SUM: begin
        pcase_q     <= mag59(pc_s);
        pcase_neg_q <= pc_s[58];
        pcoil_q     <= mag59(pk_s);
        pcoil_neg_q <= pk_s[58];
        pair_q      <= mag59(pa_s);
        pair_neg_q  <= pa_s[58];
      end
      default: ;
    endcase
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_q <= {coil_q, case_q, mean_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_HEAT;
      out_valid_q <= 1'b0;
      avg_q       <= AVG_STEPS_RST;
      inner_q     <= 32'd8692858;
      outer_q     <= 32'd3608003;
      icoil_q     <= 32'd778525;
      icase_q     <= 32'd69655;
      iair_q      <= 32'd16777;
      gain_q      <= 32'd1946157;
      coil_q      <= 32'd19660800;
      case_q      <= 32'd19660800;
      air_q       <= 32'd19660800;
      last_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_AVG_STEPS: avg_q   <= cfg_data_i[COUNT_WIDTH-1:0];
          REG_INV_INNER: inner_q <= cfg_data_i;
          REG_INV_OUTER: outer_q <= cfg_data_i;
          REG_INV_COIL:  icoil_q <= cfg_data_i;
          REG_INV_CASE:  icase_q <= cfg_data_i;
          REG_INV_AIR:   iair_q  <= cfg_data_i;
          REG_HEAT_GAIN: gain_q  <= cfg_data_i;
          REG_INIT_TEMP: begin
            coil_q <= cfg_data_i;
            case_q <= cfg_data_i;
            air_q  <= cfg_data_i;
          end
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!qstat_i.empty) begin
            last_q  <= job_i.now;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_q == 4'd11) begin
            op_q    <= OP_HEAT;
            state_q <= ST_MGO;
          end
        end
        ST_MGO: state_q <= ST_MWAIT;
        ST_MWAIT: begin
          if (mul_done) begin
            unique case (op_q)
              OP_DCASE: case_q <= advance(case_q, pcase_neg_q, delta);
              OP_DCOIL: coil_q <= advance(coil_q, pcoil_neg_q, delta);
              OP_DAIR:  air_q  <= advance(air_q, pair_neg_q, delta);
              default: ;
            endcase
            if (op_q == OP_DAIR) begin
              state_q <= ST_OUT;
            end else if (op_q == OP_FOUT) begin
              state_q <= ST_SUM;
            end else begin
              op_q    <= op_q + 4'd1;
              state_q <= ST_MGO;
            end
          end
        end
        ST_SUM: begin
          op_q    <= op_q + 4'd1;
          state_q <= ST_MGO;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/motor_thermal_rc_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motor_thermal_rc_estimator
// three-node coil/case/air thermal estimate from averaged joint torque
// ----------------------------------------------------------------------------
// Ticks are summed as they are taken; every averaging_steps ticks a job goes to
// a two-entry queue. The back end runs each job in order: it takes the job,
// does the mean division (four quotient bits a cycle), makes nine passes
// through one shared 64 x 48 multiplier, which sets the update time, sums the
// heat flows after the third pass and loads the result once the output is free.
// Ticks keep flowing while the queue has room.
module motor_thermal_rc_estimator import mtrc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [79:0]          s_axis_tdata,  // torque_sample, sim_time
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [95:0]               m_axis_tdata,  // mean_torque, case_temp, coil_temp
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i
);

  logic                   accept;
  logic                   push;
  logic                   pop;
  mtrc_job_t              job_in, job_out;
  mtrc_qstat_t            qstat;
  logic [COUNT_WIDTH-1:0] avg_steps;

  assign s_axis_tready = !qstat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mtrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .torque_i    (s_axis_tdata[31:0]),
    .now_i       (s_axis_tdata[79:32]),
    .avg_steps_i (avg_steps),
    .push_o      (push),
    .job_o       (job_in)
  );

  mtrc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (qstat)
  );

  mtrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .avg_steps_o (avg_steps),
    .qstat_i     (qstat),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty) else $error("job taken from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full) else $error("job pushed into full queue");

  a_empty_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qstat.empty && !push) |=> qstat.empty) else $error("queue filled without push");

endmodule
`default_nettype wire
